// ----- rtl/pdw_pkg.sv -----
// Shared widths, constants, register indexes and payload types of the pose delta warp block.
package pdw_pkg;

  localparam int Q_W       = 16;  // Q1.14 quaternion component
  localparam int QP_W      = 32;  // product of two quaternion components
  localparam int QS_W      = 34;  // sum of four such products
  localparam int D_W       = 20;  // delta quaternion component after rounding
  localparam int MP_W      = 38;  // product of two delta components
  localparam int MS_W      = 40;  // rotation matrix entry in Q28
  localparam int M20_W     = 32;  // rotation matrix entry in Q20
  localparam int F_W       = 32;  // scale factor in Q24
  localparam int WP_W      = 64;  // scaled entry in Q44
  localparam int WS_W      = 34;  // scaled entry in Q14 before saturation
  localparam int OUT_W     = 32;  // output entry in Q17.14
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 8;
  localparam int N_ENTRY   = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_X = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_Y = CFG_IDX_W'(3);

  localparam logic [CFG_W-1:0]         ONE_Q12  = CFG_W'(4096);
  localparam logic signed [QS_W-1:0]   RND_Q14  = QS_W'(8192);
  localparam logic signed [MS_W-1:0]   ONE_Q28  = MS_W'(64'sd268435456);
  localparam logic signed [MS_W-1:0]   RND_Q8   = MS_W'(128);
  localparam logic signed [WP_W-1:0]   RND_Q30  = WP_W'(64'sd536870912);
  localparam logic signed [WS_W-1:0]   SAT_HI   = WS_W'(64'sd2147483647);
  localparam logic signed [WS_W-1:0]   SAT_LO   = -WS_W'(64'sd2147483648);

  typedef logic signed [Q_W-1:0]   q14_t;
  typedef logic signed [D_W-1:0]   dcomp_t;
  typedef logic signed [OUT_W-1:0] entry_t;

  typedef struct packed {
    q14_t w;
    q14_t x;
    q14_t y;
    q14_t z;
  } quat_t;

  typedef struct packed {
    dcomp_t w;
    dcomp_t x;
    dcomp_t y;
    dcomp_t z;
  } dquat_t;

endpackage

// ----- rtl/pdw_if.sv -----
// Valid/ready channel interfaces for the pose pair input and the warp matrix output.
interface pdw_pose_if;
  import pdw_pkg::*;

  logic valid;
  logic ready;
  q14_t render_w;
  q14_t render_x;
  q14_t render_y;
  q14_t render_z;
  q14_t current_w;
  q14_t current_x;
  q14_t current_y;
  q14_t current_z;

  modport source (
    output valid, render_w, render_x, render_y, render_z,
    output current_w, current_x, current_y, current_z,
    input  ready
  );
  modport sink (
    input  valid, render_w, render_x, render_y, render_z,
    input  current_w, current_x, current_y, current_z,
    output ready
  );
endinterface

interface pdw_mat_if;
  import pdw_pkg::*;

  logic valid;
  logic ready;
  entry_t mat_00;
  entry_t mat_01;
  entry_t mat_02;
  entry_t mat_10;
  entry_t mat_11;
  entry_t mat_12;
  entry_t mat_20;
  entry_t mat_21;
  entry_t mat_22;

  modport source (
    output valid, mat_00, mat_01, mat_02, mat_10, mat_11, mat_12,
    output mat_20, mat_21, mat_22,
    input  ready
  );
  modport sink (
    input  valid, mat_00, mat_01, mat_02, mat_10, mat_11, mat_12,
    input  mat_20, mat_21, mat_22,
    output ready
  );
endinterface

// ----- rtl/pose_delta_uv_warp_matrix.sv -----
// Top level: delta rotation warp matrix pipeline with scale configuration registers.
// Throughput: one pose pair per cycle unless the result is stalled; six register stages,
// each holding at most one multiplier row or one adder tree, set the depth, and the whole
// pipe advances together. A stalled result holds every stage, and the input is ready
// whenever the result register is empty or being taken. Reset (synchronous, rst_n low)
// empties the pipe and sets all four scale registers to 1.0 (4096 in Q4.12).
module pose_delta_uv_warp_matrix (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pdw_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [pdw_pkg::CFG_W-1:0]       cfg_wdata,
  pdw_pose_if.sink                        in_pose,
  pdw_mat_if.source                       out_mat
);
  import pdw_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0] scale_x_r;
  logic [CFG_W-1:0] scale_y_r;
  logic [CFG_W-1:0] inv_scale_x_r;
  logic [CFG_W-1:0] inv_scale_y_r;

  // Scale factors sp[r] * si[c] in Q24, refreshed every cycle from the registers. The user
  // changes configuration only while the pipe is empty (unenforced), so the lag is harmless.
  logic [F_W-1:0] f_r   [N_ENTRY];
  logic [F_W-1:0] f_nxt [N_ENTRY];

  // Pipeline control. All stages move on en; valid bits travel with the data.
  logic   en;
  logic   s3_v_r;
  logic   s4_v_r;
  logic   s5_v_r;
  logic   out_v_r;
  logic   dq_v;
  dquat_t dq;
  quat_t  rq;
  quat_t  cq;

  logic signed [MP_W-1:0]  mp_r    [N_ENTRY];
  logic signed [MP_W-1:0]  mp_nxt  [N_ENTRY];
  logic signed [M20_W-1:0] m20_r   [N_ENTRY];
  logic signed [M20_W-1:0] m20_nxt [N_ENTRY];
  logic signed [WP_W-1:0]  wp_r    [N_ENTRY];
  logic signed [WP_W-1:0]  wp_nxt  [N_ENTRY];
  entry_t                  mat_r   [N_ENTRY];
  entry_t                  mat_nxt [N_ENTRY];

  assign en            = !out_v_r || out_mat.ready;
  assign in_pose.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r     <= ONE_Q12;
      scale_y_r     <= ONE_Q12;
      inv_scale_x_r <= ONE_Q12;
      inv_scale_y_r <= ONE_Q12;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SCALE_X:     scale_x_r     <= cfg_wdata;
        CFG_SCALE_Y:     scale_y_r     <= cfg_wdata;
        CFG_INV_SCALE_X: inv_scale_x_r <= cfg_wdata;
        CFG_INV_SCALE_Y: inv_scale_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The third row and column use 1.0, so only four factors need a real multiplier.
  always_comb begin
    logic [CFG_W-1:0] sp [3];
    logic [CFG_W-1:0] si [3];
    sp[0] = scale_x_r;     sp[1] = scale_y_r;     sp[2] = ONE_Q12;
    si[0] = inv_scale_x_r; si[1] = inv_scale_y_r; si[2] = ONE_Q12;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        f_nxt[3*r+c] = F_W'(sp[r]) * F_W'(si[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    f_r <= f_nxt;
  end

  // Stages one and two: delta quaternion.
  assign rq.w = in_pose.render_w;
  assign rq.x = in_pose.render_x;
  assign rq.y = in_pose.render_y;
  assign rq.z = in_pose.render_z;
  assign cq.w = in_pose.current_w;
  assign cq.x = in_pose.current_x;
  assign cq.y = in_pose.current_y;
  assign cq.z = in_pose.current_z;

  pdw_quat_delta u_delta (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_pose.valid),
    .rq        (rq),
    .cq        (cq),
    .out_valid (dq_v),
    .dq        (dq)
  );

  // Stage three: the nine pairwise products of the delta components.
  // Order: xx, yy, zz, xy, xz, yz, wx, wy, wz.
  always_comb begin
    mp_nxt[0] = MP_W'($signed(dq.x)) * MP_W'($signed(dq.x));
    mp_nxt[1] = MP_W'($signed(dq.y)) * MP_W'($signed(dq.y));
    mp_nxt[2] = MP_W'($signed(dq.z)) * MP_W'($signed(dq.z));
    mp_nxt[3] = MP_W'($signed(dq.x)) * MP_W'($signed(dq.y));
    mp_nxt[4] = MP_W'($signed(dq.x)) * MP_W'($signed(dq.z));
    mp_nxt[5] = MP_W'($signed(dq.y)) * MP_W'($signed(dq.z));
    mp_nxt[6] = MP_W'($signed(dq.w)) * MP_W'($signed(dq.x));
    mp_nxt[7] = MP_W'($signed(dq.w)) * MP_W'($signed(dq.y));
    mp_nxt[8] = MP_W'($signed(dq.w)) * MP_W'($signed(dq.z));
  end

  // Stage four: rotation matrix in Q28, then rounded half up to Q20.
  always_comb begin
    logic signed [MS_W-1:0] e [N_ENTRY];
    logic signed [MS_W-1:0] m [N_ENTRY];
    logic signed [MS_W-1:0] t;
    for (int k = 0; k < N_ENTRY; k++) begin
      e[k] = {{(MS_W-MP_W){mp_r[k][MP_W-1]}}, mp_r[k]};
    end
    m[0] = ONE_Q28 - ((e[1] + e[2]) <<< 1);
    m[1] = (e[3] - e[8]) <<< 1;
    m[2] = (e[4] + e[7]) <<< 1;
    m[3] = (e[3] + e[8]) <<< 1;
    m[4] = ONE_Q28 - ((e[0] + e[2]) <<< 1);
    m[5] = (e[5] - e[6]) <<< 1;
    m[6] = (e[4] - e[7]) <<< 1;
    m[7] = (e[5] + e[6]) <<< 1;
    m[8] = ONE_Q28 - ((e[0] + e[1]) <<< 1);
    for (int k = 0; k < N_ENTRY; k++) begin
      t          = m[k] + RND_Q8;
      m20_nxt[k] = t[MS_W-1:8];
    end
  end

  // Stage five: apply the projection scale factor, Q20 times Q24 gives Q44.
  // The product always fits in 64 bits, so the factor is zero-extended to that width.
  always_comb begin
    for (int k = 0; k < N_ENTRY; k++) begin
      wp_nxt[k] = WP_W'($signed(m20_r[k])) * $signed(WP_W'(f_r[k]));
    end
  end

  // Stage six: round half up to Q14 and saturate to 32 bits.
  always_comb begin
    logic signed [WP_W-1:0] t;
    logic signed [WS_W-1:0] s;
    for (int k = 0; k < N_ENTRY; k++) begin
      t = wp_r[k] + RND_Q30;
      s = t[WP_W-1:30];
      if (s > SAT_HI) begin
        mat_nxt[k] = SAT_HI[OUT_W-1:0];
      end else if (s < SAT_LO) begin
        mat_nxt[k] = SAT_LO[OUT_W-1:0];
      end else begin
        mat_nxt[k] = s[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r  <= dq_v;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      out_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mp_r  <= mp_nxt;
      m20_r <= m20_nxt;
      wp_r  <= wp_nxt;
      mat_r <= mat_nxt;
    end
  end

  assign out_mat.valid  = out_v_r;
  assign out_mat.mat_00 = mat_r[0];
  assign out_mat.mat_01 = mat_r[1];
  assign out_mat.mat_02 = mat_r[2];
  assign out_mat.mat_10 = mat_r[3];
  assign out_mat.mat_11 = mat_r[4];
  assign out_mat.mat_12 = mat_r[5];
  assign out_mat.mat_20 = mat_r[6];
  assign out_mat.mat_21 = mat_r[7];
  assign out_mat.mat_22 = mat_r[8];

  // The input only backs off when a finished result is waiting.
  a_ready_low_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pose.ready |-> out_mat.valid)
    else $error("input stalled with an empty result register");

  // A result beat can only appear out of the last arithmetic stage.
  a_out_from_stage5: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_mat.valid) |-> $past(s5_v_r))
    else $error("result beat appeared without a scaled entry behind it");

  // A stall freezes the inner stages.
  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({s3_v_r, s4_v_r, s5_v_r}))
    else $error("pipeline valid bits moved during a stall");

  // A scaled entry that moves on always lands in the result register.
  a_stage5_advances: assert property (@(posedge clk) disable iff (!rst_n)
    s5_v_r && en |=> out_mat.valid)
    else $error("scaled entry lost on its way to the result register");

endmodule

// ----- rtl/pdw_quat_delta.sv -----
// Two-stage pipeline that forms the rounded delta quaternion current * conj(render).
module pdw_quat_delta (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  pdw_pkg::quat_t  rq,
  input  pdw_pkg::quat_t  cq,
  output logic            out_valid,
  output pdw_pkg::dquat_t dq
);
  import pdw_pkg::*;

  logic signed [QP_W-1:0] p_r   [16];
  logic signed [QP_W-1:0] p_nxt [16];
  logic                   v1_r;
  logic                   v2_r;
  dquat_t                 dq_r;
  dquat_t                 dq_nxt;

  function automatic logic signed [QS_W-1:0] ext(input logic signed [QP_W-1:0] v);
    ext = {{(QS_W-QP_W){v[QP_W-1]}}, v};
  endfunction

  // Product index is 4 * current component + render component, order w, x, y, z.
  always_comb begin
    q14_t cv [4];
    q14_t rv [4];
    cv[0] = cq.w; cv[1] = cq.x; cv[2] = cq.y; cv[3] = cq.z;
    rv[0] = rq.w; rv[1] = rq.x; rv[2] = rq.y; rv[3] = rq.z;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p_nxt[4*i+j] = QP_W'($signed(cv[i])) * QP_W'($signed(rv[j]));
      end
    end
  end

  // The render conjugate is folded into the signs of the sums.
  always_comb begin
    logic signed [QS_W-1:0] sw;
    logic signed [QS_W-1:0] sx;
    logic signed [QS_W-1:0] sy;
    logic signed [QS_W-1:0] sz;
    sw = ext(p_r[0]) + ext(p_r[5]) + ext(p_r[10]) + ext(p_r[15]) + RND_Q14;
    sx = ext(p_r[4]) - ext(p_r[1]) - ext(p_r[11]) + ext(p_r[14]) + RND_Q14;
    sy = ext(p_r[7]) - ext(p_r[2]) + ext(p_r[8]) - ext(p_r[13]) + RND_Q14;
    sz = ext(p_r[9]) - ext(p_r[3]) - ext(p_r[6]) + ext(p_r[12]) + RND_Q14;
    dq_nxt.w = sw[QS_W-1:14];
    dq_nxt.x = sx[QS_W-1:14];
    dq_nxt.y = sy[QS_W-1:14];
    dq_nxt.z = sz[QS_W-1:14];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r  <= p_nxt;
      dq_r <= dq_nxt;
    end
  end

  assign out_valid = v2_r;
  assign dq        = dq_r;

endmodule

// ----- tb/sv/tb_pose_delta_uv_warp_matrix.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the pose delta warp matrix block: directed, register and random tests.
module tb_pose_delta_uv_warp_matrix;
  import pdw_pkg::*;

  // The clock period is 8 ns. Stimulus is driven on the falling edge, and results are
  // sampled on the rising edge, so no check depends on event order inside one time step.
  localparam int CLK_HALF             = 4;
  localparam int RESET_CYCLES         = 6;
  // PIPE_LATENCY sizes the settle time after a drain, so that any stray extra result still shows up.
  localparam int PIPE_LATENCY         = 6;
  localparam int RAND_POSES_PER_PHASE = 300;
  // About 1250 pose beats in total; even with heavy idling a run stays well inside this ceiling.
  localparam longint RUN_LIMIT_NS     = 64'd4_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_UNUSED = CFG_INV_SCALE_Y + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP          = {CFG_IDX_W{1'b1}};
  localparam logic [CFG_W-1:0]     SCALE_MAX            = {CFG_W{1'b1}};
  localparam logic [CFG_W-1:0]     SCALE_ZERO           = '0;

  localparam q14_t Q_ONE        = 16'sd16384;
  localparam q14_t Q_NEG_ONE    = -16'sd16384;
  localparam q14_t Q_MIN        = 16'sh8000;
  localparam q14_t Q_MAX        = 16'sh7fff;
  localparam q14_t Q_ZERO       = 16'sd0;
  localparam q14_t Q_HALF_SQRT2 = 16'sd11585;  // cos(45 deg), the half angle of a 90 deg turn

  typedef struct packed {
    quat_t render;
    quat_t current;
  } pose_pair_t;

  // Entry i of a matrix is row i/3 and column i%3.
  typedef logic [N_ENTRY-1:0][OUT_W-1:0] warp_mat_t;

  typedef enum int {
    DRAW_UNIT,
    DRAW_NEAR_ID,
    DRAW_RANGE,
    DRAW_RAW,
    DRAW_EDGE
  } draw_kind_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  pdw_pose_if pose_ch ();
  pdw_mat_if  mat_ch ();

  pose_delta_uv_warp_matrix dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_pose  (pose_ch.sink),
    .out_mat  (mat_ch.source)
  );

  // The testbench's own copy of the four scale registers, updated on every write.
  logic [CFG_W-1:0] held_scale_x;
  logic [CFG_W-1:0] held_scale_y;
  logic [CFG_W-1:0] held_inv_scale_x;
  logic [CFG_W-1:0] held_inv_scale_y;

  // Expected matrices in the order their pose beats were accepted.
  warp_mat_t warp_due [$];
  int        mismatch_count;

  // Idling odds, in percent per cycle, for the pose sender and the matrix receiver.
  int send_idle_pct;
  int recv_stall_pct;

  string entry_name [N_ENTRY] = '{"mat_00", "mat_01", "mat_02",
                                  "mat_10", "mat_11", "mat_12",
                                  "mat_20", "mat_21", "mat_22"};

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Divide by 2^sh, rounding half up. An arithmetic shift of a signed value is a floor.
  function automatic longint round_half_up(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Predicts the warp matrix for one pose pair under the scale registers held right now.
  function automatic warp_mat_t compute_warp(pose_pair_t p);
    longint    rw, rx, ry, rz, cw, cx, cy, cz;
    longint    dw, dx, dy, dz;
    longint    one28;
    longint    rot [N_ENTRY];
    longint    row_gain [3];
    longint    col_gain [3];
    longint    m20, scaled;
    warp_mat_t res;
    // The render quaternion is conjugated, so its vector part changes sign.
    rw = longint'($signed(p.render.w));
    rx = -longint'($signed(p.render.x));
    ry = -longint'($signed(p.render.y));
    rz = -longint'($signed(p.render.z));
    cw = longint'($signed(p.current.w));
    cx = longint'($signed(p.current.x));
    cy = longint'($signed(p.current.y));
    cz = longint'($signed(p.current.z));
    // Delta rotation: current times conjugated render, brought back to Q14.
    dw = round_half_up(cw * rw - cx * rx - cy * ry - cz * rz, 14);
    dx = round_half_up(cw * rx + cx * rw + cy * rz - cz * ry, 14);
    dy = round_half_up(cw * ry - cx * rz + cy * rw + cz * rx, 14);
    dz = round_half_up(cw * rz + cx * ry - cy * rx + cz * rw, 14);
    // Rotation matrix in Q28. No normalization, whatever the input magnitude.
    one28  = longint'(ONE_Q28);
    rot[0] = one28 - 2 * (dy * dy + dz * dz);
    rot[1] = 2 * (dx * dy - dw * dz);
    rot[2] = 2 * (dx * dz + dw * dy);
    rot[3] = 2 * (dx * dy + dw * dz);
    rot[4] = one28 - 2 * (dx * dx + dz * dz);
    rot[5] = 2 * (dy * dz - dw * dx);
    rot[6] = 2 * (dx * dz - dw * dy);
    rot[7] = 2 * (dy * dz + dw * dx);
    rot[8] = one28 - 2 * (dx * dx + dy * dy);
    row_gain = '{longint'(held_scale_x), longint'(held_scale_y), longint'(ONE_Q12)};
    col_gain = '{longint'(held_inv_scale_x), longint'(held_inv_scale_y), longint'(ONE_Q12)};
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m20    = round_half_up(rot[r * 3 + c], 8);
        scaled = round_half_up(m20 * row_gain[r] * col_gain[c], 30);
        if (scaled > longint'(SAT_HI)) begin
          scaled = longint'(SAT_HI);
        end else if (scaled < longint'(SAT_LO)) begin
          scaled = longint'(SAT_LO);
        end
        res[r * 3 + c] = OUT_W'(scaled);
      end
    end
    return res;
  endfunction

  function automatic pose_pair_t pose_of(q14_t rw, q14_t rx, q14_t ry, q14_t rz,
                                         q14_t cw, q14_t cx, q14_t cy, q14_t cz);
    pose_pair_t p;
    p.render  = '{w: rw, x: rx, y: ry, z: rz};
    p.current = '{w: cw, x: cx, y: cy, z: cz};
    return p;
  endfunction

  // Draws one quaternion. Unit and near-identity draws are what a head tracker sends;
  // the others cover +-1.0, the full bit range and its edges, since the block never normalizes.
  function automatic quat_t draw_quat(draw_kind_t kind);
    real  a [4];
    real  norm;
    q14_t comp [4];
    q14_t edges [7];
    edges = '{Q_MIN, Q_NEG_ONE, -16'sd1, Q_ZERO, 16'sd1, Q_ONE, Q_MAX};
    case (kind)
      DRAW_UNIT: begin
        norm = 0.0;
        for (int i = 0; i < 4; i++) begin
          a[i] = $itor($urandom_range(2000)) - 1000.0;
          norm = norm + a[i] * a[i];
        end
        if (norm == 0.0) begin
          comp = '{Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO};
        end else begin
          norm = $sqrt(norm);
          for (int i = 0; i < 4; i++) comp[i] = q14_t'($rtoi(a[i] * 16384.0 / norm));
        end
      end
      DRAW_NEAR_ID: begin
        comp[0] = q14_t'(Q_ONE - $urandom_range(400));
        for (int i = 1; i < 4; i++) comp[i] = q14_t'($urandom_range(1600) - 800);
      end
      DRAW_RANGE: begin
        for (int i = 0; i < 4; i++) comp[i] = q14_t'($urandom_range(32768) - 16384);
      end
      DRAW_RAW: begin
        for (int i = 0; i < 4; i++) comp[i] = q14_t'($urandom);
      end
      default: begin
        for (int i = 0; i < 4; i++) comp[i] = edges[$urandom_range(6)];
      end
    endcase
    return '{w: comp[0], x: comp[1], y: comp[2], z: comp[3]};
  endfunction

  function automatic draw_kind_t pick_draw();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return DRAW_UNIT;
    if (roll < 65) return DRAW_NEAR_ID;
    if (roll < 80) return DRAW_RANGE;
    if (roll < 90) return DRAW_RAW;
    return DRAW_EDGE;
  endfunction

  // Mostly both quaternions come from the same kind of draw, as a real pose pair would.
  function automatic pose_pair_t draw_pose();
    draw_kind_t kind;
    pose_pair_t p;
    kind      = pick_draw();
    p.render  = draw_quat(kind);
    p.current = draw_quat(($urandom_range(99) < 80) ? kind : pick_draw());
    return p;
  endfunction

  function automatic logic [CFG_W-1:0] pick_scale();
    case ($urandom_range(6))
      0:       return SCALE_MAX;
      1:       return ONE_Q12;
      2:       return SCALE_ZERO;
      3:       return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(12000, 1024));
    endcase
  endfunction

  // One register write. The enable drops for a cycle before the task returns, so that
  // back-to-back writes never raise and lower it at the same edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SCALE_X:     held_scale_x     = value;
      CFG_SCALE_Y:     held_scale_y     = value;
      CFG_INV_SCALE_X: held_inv_scale_x = value;
      CFG_INV_SCALE_Y: held_inv_scale_y = value;
      default: ;  // indexes past the register file are dropped by the block
    endcase
    @(negedge clk);
  endtask

  task automatic write_scales(logic [CFG_W-1:0] sx, logic [CFG_W-1:0] sy,
                              logic [CFG_W-1:0] isx, logic [CFG_W-1:0] isy);
    write_reg(CFG_SCALE_X, sx);
    write_reg(CFG_SCALE_Y, sy);
    write_reg(CFG_INV_SCALE_X, isx);
    write_reg(CFG_INV_SCALE_Y, isy);
  endtask

  // Sends one pose beat. Entered and left on a falling edge. Valid is only lowered when
  // an idle gap is taken, so a run of beats keeps it high without a glitch.
  task automatic send_pose(pose_pair_t p);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      pose_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    pose_ch.valid     <= 1'b1;
    pose_ch.render_w  <= p.render.w;
    pose_ch.render_x  <= p.render.x;
    pose_ch.render_y  <= p.render.y;
    pose_ch.render_z  <= p.render.z;
    pose_ch.current_w <= p.current.w;
    pose_ch.current_x <= p.current.x;
    pose_ch.current_y <= p.current.y;
    pose_ch.current_z <= p.current.z;
    do @(posedge clk); while (!pose_ch.ready);
    // The beat is taken at this edge; the prediction uses the registers as they stand.
    warp_due.push_back(compute_warp(p));
    @(negedge clk);
  endtask

  // Stops sending and waits until every expected matrix has arrived, then a little longer
  // so that a surplus result would still be caught before the next register write.
  task automatic drain_pipe();
    pose_ch.valid <= 1'b0;
    while (warp_due.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY * 4) @(negedge clk);
  endtask

  // Reset scales give an identity projection, so the result is the bare rotation matrix.
  // Covers the quaternion extremes, quarter and half turns, sign flips and non-unit input.
  task automatic check_reset_identity();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_pose(pose_of(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO));
    send_pose(pose_of(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_HALF_SQRT2, Q_HALF_SQRT2, Q_ZERO, Q_ZERO));
    send_pose(pose_of(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_HALF_SQRT2, Q_ZERO, Q_HALF_SQRT2, Q_ZERO));
    send_pose(pose_of(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_HALF_SQRT2, Q_ZERO, Q_ZERO, Q_HALF_SQRT2));
    send_pose(pose_of(Q_HALF_SQRT2, Q_ZERO, Q_ZERO, Q_HALF_SQRT2, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO));
    // The negated quaternion is the same rotation.
    send_pose(pose_of(Q_NEG_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO));
    send_pose(pose_of(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO));
    send_pose(pose_of(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
    send_pose(pose_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_pose(pose_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_pose(pose_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_pose(pose_of(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    send_pose(pose_of(Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    send_pose(pose_of(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_NEG_ONE, Q_ONE, Q_NEG_ONE, Q_ONE));
    // Tiny components land right on the rounding boundaries.
    send_pose(pose_of(16'sd1, -16'sd1, 16'sd1, -16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1));
    drain_pipe();
  endtask

  // Walks through scale settings: all zero (whole rows and columns vanish), all maximum
  // (the output saturates for large input), mixed extremes, a typical field of view and 1.0.
  // Writes to indexes past the register file are mixed in and must change nothing.
  task automatic check_scale_registers();
    logic [CFG_W-1:0] scale_sets [6][4];
    scale_sets = '{'{SCALE_ZERO, SCALE_ZERO, SCALE_ZERO, SCALE_ZERO},
                   '{SCALE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX},
                   '{SCALE_MAX, SCALE_ZERO, SCALE_ZERO, SCALE_MAX},
                   '{SCALE_ZERO, SCALE_MAX, SCALE_MAX, SCALE_ZERO},
                   '{16'd2458, 16'd2048, 16'd6827, 16'd8192},
                   '{ONE_Q12, ONE_Q12, ONE_Q12, ONE_Q12}};
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    foreach (scale_sets[s]) begin
      write_scales(scale_sets[s][0], scale_sets[s][1], scale_sets[s][2], scale_sets[s][3]);
      write_reg(CFG_IDX_FIRST_UNUSED, CFG_W'($urandom));
      write_reg(CFG_IDX_TOP, CFG_W'($urandom));
      send_pose(pose_of(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_HALF_SQRT2, Q_ZERO, Q_ZERO, Q_HALF_SQRT2));
      send_pose(pose_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      send_pose(pose_of(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
      send_pose(pose_of(Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN, Q_MIN, Q_MIN));
      send_pose(draw_pose());
      send_pose(draw_pose());
      drain_pipe();
    end
  endtask

  // Random pose pairs in four idling phases: none, sender gaps, receiver stalls, both.
  // Each phase runs under freshly drawn scales, written while the pipe is empty.
  task automatic run_random_poses();
    int send_pct [4];
    int recv_pct [4];
    send_pct = '{0, 50, 0, 26};
    recv_pct = '{0, 0, 50, 26};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      write_scales(pick_scale(), pick_scale(), pick_scale(), pick_scale());
      repeat (RAND_POSES_PER_PHASE) send_pose(draw_pose());
      drain_pipe();
    end
  endtask

  // Receiver: ready is redrawn every falling edge according to the current stall odds.
  always @(negedge clk) begin
    mat_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result check: every matrix beat is matched against the oldest prediction.
  always @(posedge clk) begin
    warp_mat_t want;
    warp_mat_t seen;
    if (rst_n && mat_ch.valid && mat_ch.ready) begin
      seen = {mat_ch.mat_22, mat_ch.mat_21, mat_ch.mat_20,
              mat_ch.mat_12, mat_ch.mat_11, mat_ch.mat_10,
              mat_ch.mat_02, mat_ch.mat_01, mat_ch.mat_00};
      if (warp_due.size() == 0) begin
        $error("matrix beat arrived with no pose pair outstanding");
        mismatch_count++;
      end else begin
        want = warp_due.pop_front();
        for (int i = 0; i < N_ENTRY; i++) begin
          if (seen[i] !== want[i]) begin
            $error("%s: expected %0d, actual %0d", entry_name[i],
                   $signed(want[i]), $signed(seen[i]));
            mismatch_count++;
          end
        end
      end
    end
  end

  // Main sequence. Every input is known from time zero, before reset is released.
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_SCALE_X;
    cfg_wdata         = ONE_Q12;
    pose_ch.valid     = 1'b0;
    pose_ch.render_w  = Q_ZERO;
    pose_ch.render_x  = Q_ZERO;
    pose_ch.render_y  = Q_ZERO;
    pose_ch.render_z  = Q_ZERO;
    pose_ch.current_w = Q_ZERO;
    pose_ch.current_x = Q_ZERO;
    pose_ch.current_y = Q_ZERO;
    pose_ch.current_z = Q_ZERO;
    mat_ch.ready      = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    mismatch_count    = 0;
    held_scale_x      = ONE_Q12;
    held_scale_y      = ONE_Q12;
    held_inv_scale_x  = ONE_Q12;
    held_inv_scale_y  = ONE_Q12;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    check_reset_identity();
    check_scale_registers();
    run_random_poses();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog in case the handshake hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
